// File: rtl/mse_pkg.sv
// merge sort engine: shared constants and the command and status bundles
// passed between the controller and the datapath; no dependencies
`default_nettype none

package mse_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 64;

	typedef struct packed {
		logic load;
		logic sort_init;
		logic pass_start;
		logic run_start;
		logic merge_rd;
		logic merge_wr;
		logic emit_start;
		logic emit_rd;
		logic emit_wr;
	} mse_cmd_t;

	typedef struct packed {
		logic pass_done;
		logic run_last;
		logic pass_last;
		logic emit_last;
		logic out_free;
	} mse_sts_t;

endpackage

`default_nettype wire

// File: rtl/mse_datapath.sv
// merge sort engine datapath: the two merge memories, run pointers,
// batch count, overflow flag and output register; uses mse_pkg
`default_nettype none

module mse_datapath
	import mse_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mse_cmd_t          cmd,
	output mse_sts_t               sts,
	input  wire logic [DATA_W-1:0] in_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [DATA_W-1:0]      out_value,
	output logic                   out_last,
	output logic                   out_ovf
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = CNT_W + 2;
	localparam int AW    = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	logic [DATA_W-1:0] store_mem   [CAPACITY];
	logic [DATA_W-1:0] scratch_mem [CAPACITY];

	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic              src_sel_q;
	logic [PW-1:0]     width_q;
	logic [PW-1:0]     lo_q;
	logic [PW-1:0]     mid_q;
	logic [PW-1:0]     hi_q;
	logic [PW-1:0]     a_q;
	logic [PW-1:0]     b_q;
	logic [PW-1:0]     k_q;
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic [PW-1:0]     n_w;
	logic [PW-1:0]     lo_w;
	logic [PW-1:0]     lo_2w;
	logic [PW-1:0]     mid_n;
	logic [PW-1:0]     hi_n;
	logic              take_a;
	logic              room;
	logic [AW-1:0]     rd_addr_a;
	logic [AW-1:0]     rd_addr_b;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              store_we;
	logic              scratch_we;

	always_comb begin
		n_w        = PW'(count_q);
		lo_w       = lo_q + width_q;
		lo_2w      = lo_q + (width_q << 1);
		mid_n      = (lo_w < n_w) ? lo_w : n_w;
		hi_n       = (lo_2w < n_w) ? lo_2w : n_w;
		take_a     = (a_q < mid_q) && ((b_q >= hi_q) || (rd_a_q <= rd_b_q));
		room       = count_q < CAP_C;
		rd_addr_a  = cmd.emit_rd ? k_q[AW-1:0] : a_q[AW-1:0];
		rd_addr_b  = b_q[AW-1:0];
		wr_addr    = cmd.load ? count_q[AW-1:0] : k_q[AW-1:0];
		wr_data    = cmd.load ? in_value : (take_a ? rd_a_q : rd_b_q);
		store_we   = (cmd.load && room) || (cmd.merge_wr && src_sel_q);
		scratch_we = cmd.merge_wr && !src_sel_q;
	end

	always_comb begin
		sts.pass_done = width_q >= n_w;
		sts.run_last  = (k_q + PW'(1)) == hi_q;
		sts.pass_last = lo_2w >= n_w;
		sts.emit_last = (k_q + PW'(1)) == n_w;
		sts.out_free  = !out_valid_q || out_ready;
	end

	// memories
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[wr_addr] <= wr_data;
		end
		if (scratch_we) begin
			scratch_mem[wr_addr] <= wr_data;
		end
		if (cmd.merge_rd || cmd.emit_rd) begin
			rd_a_q <= src_sel_q ? scratch_mem[rd_addr_a] : store_mem[rd_addr_a];
			rd_b_q <= src_sel_q ? scratch_mem[rd_addr_b] : store_mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			src_sel_q   <= 1'b0;
			width_q     <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.sort_init) begin
				width_q   <= PW'(1);
				src_sel_q <= 1'b0;
			end
			if (cmd.pass_start) begin
				lo_q <= '0;
			end
			if (cmd.run_start) begin
				mid_q <= mid_n;
				hi_q  <= hi_n;
				a_q   <= lo_q;
				b_q   <= mid_n;
				k_q   <= lo_q;
			end
			if (cmd.merge_wr) begin
				if (take_a) begin
					a_q <= a_q + PW'(1);
				end else begin
					b_q <= b_q + PW'(1);
				end
				k_q <= k_q + PW'(1);
				if (sts.run_last) begin
					lo_q <= lo_2w;
					if (sts.pass_last) begin
						width_q   <= width_q << 1;
						src_sel_q <= ~src_sel_q;
					end
				end
			end
			if (cmd.emit_start) begin
				k_q <= '0;
			end
			if (cmd.emit_wr) begin
				k_q <= k_q + PW'(1);
				if (sts.emit_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
			if (cmd.emit_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_wr) begin
			out_value_q <= rd_a_q;
			out_last_q  <= sts.emit_last;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

endmodule

`default_nettype wire

// File: rtl/mse_ctrl.sv
// merge sort engine controller: state machine sequencing load, merge
// passes and emission; drives mse_datapath through mse_pkg bundles
`default_nettype none

module mse_ctrl
	import mse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	output logic          in_ready,
	output mse_cmd_t      cmd,
	input  wire mse_sts_t sts
);

	typedef enum logic [6:0] {
		S_LOAD = 7'b0000001,
		S_PASS = 7'b0000010,
		S_RUN  = 7'b0000100,
		S_RD   = 7'b0001000,
		S_WR   = 7'b0010000,
		S_ERD  = 7'b0100000,
		S_EWR  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.sort_init = 1'b1;
						state_nxt     = S_PASS;
					end
				end
			end
			S_PASS: begin
				if (sts.pass_done) begin
					cmd.emit_start = 1'b1;
					state_nxt      = S_ERD;
				end else begin
					cmd.pass_start = 1'b1;
					state_nxt      = S_RUN;
				end
			end
			S_RUN: begin
				cmd.run_start = 1'b1;
				state_nxt     = S_RD;
			end
			S_RD: begin
				cmd.merge_rd = 1'b1;
				state_nxt    = S_WR;
			end
			S_WR: begin
				cmd.merge_wr = 1'b1;
				if (sts.run_last) begin
					state_nxt = sts.pass_last ? S_PASS : S_RUN;
				end else begin
					state_nxt = S_RD;
				end
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
				state_nxt   = S_EWR;
			end
			S_EWR: begin
				if (sts.out_free) begin
					cmd.emit_wr = 1'b1;
					state_nxt   = sts.emit_last ? S_LOAD : S_ERD;
				end
			end
			default: begin
				state_nxt = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/merge_sort_engine_core.sv
// merge sort engine top level: joins mse_ctrl and mse_datapath
// depends on mse_pkg, mse_ctrl, mse_datapath
// loading accepts one beat per cycle; the beat with tlast starts the sort
// merging: each pass opens with a pass state, each run with a run state, and each element
// takes a memory read state then a compare and write state; ceil(log2 n) passes
// emission: a registered memory read per result, then a write once the output is free
// reset: asynchronous, clears count, overflow flag, state and output valid; memories keep
`default_nettype none

module merge_sort_engine_core
	import mse_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [DATA_W-1:0] s_axis_tdata,  // value
	input  wire logic              s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,  // sorted_value
	output logic                   m_axis_tlast,
	output logic [0:0]             m_axis_tuser   // overflow
);

	mse_cmd_t cmd;
	mse_sts_t sts;

	mse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mse_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser[0])
	);

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_wr |-> sts.out_free)
		else $error("result written over a stalled beat");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.run_start, cmd.merge_rd, cmd.merge_wr,
			cmd.emit_rd, cmd.emit_wr}))
		else $error("conflicting datapath commands");

	a_final_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_wr && sts.emit_last |=> m_axis_tvalid && m_axis_tlast)
		else $error("final result not marked");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !cmd.merge_wr && !cmd.emit_wr)
		else $error("input taken while sorting");
`endif

endmodule

`default_nettype wire
